/* sv/frequency_ranked_key_list_defines.svh */
// Assertion macros for the frequency-ranked key list.
// Used by the top level; expects clk and arst_n in scope.
`ifndef FREQUENCY_RANKED_KEY_LIST_DEFINES_SVH
`define FREQUENCY_RANKED_KEY_LIST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRKL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRKL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/frkl_pkg.sv */
// Shared types and constants of the frequency-ranked key list.
// No dependencies; imported by the cell, the gather logic and the top level.
package frkl_pkg;

	localparam int IN_KEY_W    = 32;
	localparam int OUT_COUNT_W = 16;
	localparam int RANK_W      = 6;
	localparam int STATUS_W    = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_LOCATE,
		ST_COMMIT
	} state_t;

	// Per-cycle commands broadcast to every cell of the chain.
	typedef struct packed {
		logic search_en;
		logic by_index;
		logic move_en;
		logic append_en;
	} cell_ctl_t;

endpackage

/* sv/frequency_ranked_key_list.sv */
// Top level of the frequency-ranked key list: sequencer, cell chain and result register.
// Depends on frkl_pkg, frkl_cell, frkl_gather and frequency_ranked_key_list_defines.svh.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_stall    cmd, item_key
//   output   out_valid / out_stall  result_key, result_count, result_rank, status
//
// Each request passes through acceptance, a parallel match in every cell, a gather
// of the matching entry, and a commit in which the chain shifts by one place.
// The commit waits while the previous result is still stalled at the output register.
// Reset clears the fill level, the round-robin cursor and the sequencer; the key and
// count stores are not cleared, and positions at or beyond the fill level are never read.
`include "frequency_ranked_key_list_defines.svh"

module frequency_ranked_key_list import frkl_pkg::*; #(
	parameter int ENTRIES    = 64,
	parameter int KEY_BITS   = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   cmd,
	input  logic [IN_KEY_W-1:0]    item_key,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [IN_KEY_W-1:0]    result_key,
	output logic [OUT_COUNT_W-1:0] result_count,
	output logic [RANK_W-1:0]      result_rank,
	output logic [STATUS_W-1:0]    status
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [CNT_W-1:0]      FULL_LEVEL = CNT_W'(ENTRIES);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

	// Sequencer and request registers.
	state_t                state_q, state_d;
	logic                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [IDX_W-1:0]      cur_q;
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      cursor_q;

	// Gathered entry of the current request.
	logic                  hit_any_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [KEY_BITS-1:0]   hit_key_q;
	logic [COUNT_BITS-1:0] newc_q;

	// Output register.
	logic                  out_valid_q;
	logic [IN_KEY_W-1:0]   res_key_q;
	logic [OUT_COUNT_W-1:0] res_count_q;
	logic [RANK_W-1:0]     res_rank_q;
	logic [STATUS_W-1:0]   res_status_q;

	// Chain wiring.
	cell_ctl_t             ctl;
	logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
	logic [COUNT_BITS-1:0] cell_count [ENTRIES];
	logic [ENTRIES-1:0]    hit_vec;
	logic [ENTRIES-1:0]    mark_vec;
	logic [ENTRIES-1:0]    start_vec;

	logic                  sel_any;
	logic [IDX_W-1:0]      sel_idx;
	logic [KEY_BITS-1:0]   sel_key;
	logic [COUNT_BITS-1:0] sel_count;
	logic                  start_any;
	logic [IDX_W-1:0]      start_idx;

	logic                     accept;
	logic                     go;
	logic [IDX_W-1:0]         cur_eff;
	logic [KEY_BITS-1:0]      key_in;
	logic [KEY_BITS+IN_KEY_W-1:0] key_in_wide;
	logic [IN_KEY_W+KEY_BITS-1:0] res_key_wide;
	logic [OUT_COUNT_W+COUNT_BITS-1:0] res_count_wide;
	logic [RANK_W+IDX_W-1:0]  res_rank_wide;
	logic [KEY_BITS-1:0]      res_key_d;
	logic [COUNT_BITS-1:0]    res_count_d;
	logic [IDX_W-1:0]         res_rank_d;
	logic [STATUS_W-1:0]      res_status_d;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// The key is taken modulo 2^KEY_BITS, whichever side is wider.
	assign key_in_wide = {{KEY_BITS{1'b0}}, item_key};
	assign key_in      = key_in_wide[KEY_BITS-1:0];

	// A cursor that ran past the fill level wraps to the front before use.
	assign cur_eff = (cursor_q >= fill_q) ? '0 : cursor_q[IDX_W-1:0];

	// The commit may only proceed when the output register is free or being drained.
	assign go = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and chain commands.
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				ctl.search_en = 1'b1;
				ctl.by_index  = cmd_q;
				state_d       = ST_LOCATE;
			end
			ST_LOCATE: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (go) begin
					state_d = ST_IDLE;
					if (!cmd_q) begin
						ctl.move_en   = hit_any_q;
						ctl.append_en = !hit_any_q && (fill_q != FULL_LEVEL);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result of the commit cycle, before resizing to the port widths.
	always_comb begin
		res_key_d    = key_q;
		res_count_d  = '0;
		res_rank_d   = '0;
		res_status_d = STATUS_OK;
		if (cmd_q) begin
			if (fill_q == '0) begin
				res_key_d    = '0;
				res_status_d = STATUS_EMPTY;
			end else begin
				res_key_d   = hit_key_q;
				res_count_d = newc_q;
				res_rank_d  = cur_q;
			end
		end else if (hit_any_q) begin
			res_count_d = newc_q;
			// A saturated entry has no cell to move, so it keeps its own place.
			res_rank_d  = start_any ? start_idx : hit_idx_q;
		end else if (fill_q != FULL_LEVEL) begin
			res_count_d = COUNT_BITS'(1);
			res_rank_d  = fill_q[IDX_W-1:0];
		end else begin
			res_status_d = STATUS_FULL;
		end
	end

	assign res_key_wide   = {{IN_KEY_W{1'b0}}, res_key_d};
	assign res_count_wide = {{OUT_COUNT_W{1'b0}}, res_count_d};
	assign res_rank_wide  = {{RANK_W{1'b0}}, res_rank_d};

	// Request registers and list bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			cursor_q <= '0;
		end else if (go) begin
			if (ctl.append_en) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd_q && (fill_q != '0)) begin
				cursor_q <= {1'b0, cur_q} + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= key_in;
		end
		if (state_q == ST_SEARCH) begin
			cur_q <= cur_eff;
		end
		if (state_q == ST_LOCATE) begin
			hit_any_q <= sel_any;
			hit_idx_q <= sel_idx;
			hit_key_q <= sel_key;
			if (cmd_q || (sel_count == COUNT_MAX)) begin
				newc_q <= sel_count;
			end else begin
				newc_q <= sel_count + COUNT_BITS'(1);
			end
		end
	end

	// Output register: loaded at commit, held while the consumer stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_key_q    <= res_key_wide[IN_KEY_W-1:0];
			res_count_q  <= res_count_wide[OUT_COUNT_W-1:0];
			res_rank_q   <= res_rank_wide[RANK_W-1:0];
			res_status_q <= res_status_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_key   = res_key_q;
	assign result_count = res_count_q;
	assign result_rank  = res_rank_q;
	assign status       = res_status_q;

	// The cell chain: each cell sees its front neighbor's entry and move flag.
	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		logic [KEY_BITS-1:0]   prev_key;
		logic [COUNT_BITS-1:0] prev_count;
		logic                  prev_mark;

		if (k == 0) begin : g_head
			assign prev_key   = '0;
			assign prev_count = '0;
			assign prev_mark  = 1'b0;
		end else begin : g_link
			assign prev_key   = cell_key[k-1];
			assign prev_count = cell_count[k-1];
			assign prev_mark  = mark_vec[k-1];
		end

		frkl_cell #(
			.KEY_BITS   (KEY_BITS),
			.COUNT_BITS (COUNT_BITS),
			.IDX_W      (IDX_W),
			.INDEX      (k)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.bcast_key   (key_q),
			.bcast_count (newc_q),
			.bcast_idx   (cur_eff),
			.fill        (fill_q),
			.hit_idx     (hit_idx_q),
			.prev_key    (prev_key),
			.prev_count  (prev_count),
			.prev_mark   (prev_mark),
			.entry_key   (cell_key[k]),
			.entry_count (cell_count[k]),
			.hit         (hit_vec[k]),
			.mark        (mark_vec[k]),
			.start       (start_vec[k])
		);
	end

	frkl_gather #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W)
	) u_gather (
		.sel       (hit_vec),
		.start     (start_vec),
		.keys      (cell_key),
		.counts    (cell_count),
		.sel_any   (sel_any),
		.sel_idx   (sel_idx),
		.sel_key   (sel_key),
		.sel_count (sel_count),
		.start_any (start_any),
		.start_idx (start_idx)
	);

	// Keys are unique in the list, so at most one cell can match.
	`FRKL_ASSERT_NOW(a_single_hit, state_q == ST_LOCATE, $onehot0(hit_vec), "more than one cell matched")
	// A moved entry never lands behind the place where it was found.
	`FRKL_ASSERT_NOW(a_move_forward, go && ctl.move_en && start_any, start_idx <= hit_idx_q, "entry moved backward")
	// An append grows the list by exactly one entry.
	`FRKL_ASSERT_NEXT(a_append_fill, go && ctl.append_en, fill_q == $past(fill_q) + CNT_W'(1), "fill level did not grow on append")

endmodule

/* sv/frkl_cell.sv */
// One list position: holds a key and its count, matches, and shifts toward the back.
// Depends on frkl_pkg for the command struct.
module frkl_cell import frkl_pkg::*; #(
	parameter int KEY_BITS   = 32,
	parameter int COUNT_BITS = 16,
	parameter int IDX_W      = 6,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	input  logic [KEY_BITS-1:0]   bcast_key,
	input  logic [COUNT_BITS-1:0] bcast_count,
	input  logic [IDX_W-1:0]      bcast_idx,
	input  logic [IDX_W:0]        fill,
	input  logic [IDX_W-1:0]      hit_idx,
	input  logic [KEY_BITS-1:0]   prev_key,
	input  logic [COUNT_BITS-1:0] prev_count,
	input  logic                  prev_mark,
	output logic [KEY_BITS-1:0]   entry_key,
	output logic [COUNT_BITS-1:0] entry_count,
	output logic                  hit,
	output logic                  mark,
	output logic                  start
);

	localparam logic [IDX_W:0]   POS   = (IDX_W+1)'(INDEX);
	localparam logic [IDX_W-1:0] POS_I = POS[IDX_W-1:0];

	logic [KEY_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  hit_q;

	// A cell moves when it lies at or before the hit and its count is now beaten.
	assign mark  = (POS_I <= hit_idx) && (count_q < bcast_count);
	assign start = mark && !prev_mark;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.search_en) begin
			if (ctl.by_index) begin
				hit_q <= (POS_I == bcast_idx);
			end else begin
				hit_q <= (POS < fill) && (key_q == bcast_key);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.move_en && mark) begin
			if (prev_mark) begin
				key_q   <= prev_key;
				count_q <= prev_count;
			end else begin
				key_q   <= bcast_key;
				count_q <= bcast_count;
			end
		end else if (ctl.append_en && (POS == fill)) begin
			key_q   <= bcast_key;
			count_q <= COUNT_BITS'(1);
		end
	end

	assign entry_key   = key_q;
	assign entry_count = count_q;
	assign hit         = hit_q;

endmodule

/* sv/frkl_gather.sv */
// AND-OR gather over the cell chain: picks the selected entry and encodes positions.
// Depends on frkl_pkg only by convention; selection vectors are at most one-hot.
module frkl_gather import frkl_pkg::*; #(
	parameter int ENTRIES    = 64,
	parameter int KEY_BITS   = 32,
	parameter int COUNT_BITS = 16,
	parameter int IDX_W      = 6
) (
	input  logic [ENTRIES-1:0]    sel,
	input  logic [ENTRIES-1:0]    start,
	input  logic [KEY_BITS-1:0]   keys   [ENTRIES],
	input  logic [COUNT_BITS-1:0] counts [ENTRIES],
	output logic                  sel_any,
	output logic [IDX_W-1:0]      sel_idx,
	output logic [KEY_BITS-1:0]   sel_key,
	output logic [COUNT_BITS-1:0] sel_count,
	output logic                  start_any,
	output logic [IDX_W-1:0]      start_idx
);

	always_comb begin
		sel_any   = 1'b0;
		sel_idx   = '0;
		sel_key   = '0;
		sel_count = '0;
		start_any = 1'b0;
		start_idx = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			if (sel[k]) begin
				sel_any   = 1'b1;
				sel_idx   = sel_idx | IDX_W'(k);
				sel_key   = sel_key | keys[k];
				sel_count = sel_count | counts[k];
			end
			if (start[k]) begin
				start_any = 1'b1;
				start_idx = start_idx | IDX_W'(k);
			end
		end
	end

endmodule

/* sim/tb_frequency_ranked_key_list.sv */
// Self-checking testbench for the frequency-ranked key list.
// Depends on frkl_pkg and the frequency_ranked_key_list top level; it needs no other files.
// It runs a directed table and random record/next traffic against a shadow list.
module tb_frequency_ranked_key_list import frkl_pkg::*; ();

	localparam int LIST_DEPTH     = 64;
	localparam int RANDOM_ITEMS   = 680;
	localparam int IDLE_PERCENT   = 26;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int DIRECTED_ROWS  = 21;
	localparam int PRINT_CAP      = 30;

	// Command codes carried on the cmd port.
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_NEXT   = 1'b1;

	// One result as the block reports it.
	typedef struct packed {
		logic [IN_KEY_W-1:0]    key;
		logic [OUT_COUNT_W-1:0] count;
		logic [RANK_W-1:0]      rank;
		logic [STATUS_W-1:0]    status;
	} listing_t;

	// One row of the directed table. When typed is set, want is the result written
	// out by hand; otherwise the shadow list supplies the expected result.
	typedef struct packed {
		logic                cmd;
		logic [IN_KEY_W-1:0] key;
		logic                typed;
		listing_t            want;
	} directed_row_t;

	localparam listing_t NO_WANT = '0;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   cmd;
	logic [IN_KEY_W-1:0]    item_key;
	logic                   out_valid;
	logic                   out_stall;
	logic [IN_KEY_W-1:0]    result_key;
	logic [OUT_COUNT_W-1:0] result_count;
	logic [RANK_W-1:0]      result_rank;
	logic [STATUS_W-1:0]    status;

	frequency_ranked_key_list DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.item_key     (item_key),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_key   (result_key),
		.result_count (result_count),
		.result_rank  (result_rank),
		.status       (status)
	);

	// Shadow copy of the list: keys and counts ordered by count, plus the fill level
	// and the round-robin cursor.
	logic [IN_KEY_W-1:0]    mirror_key   [LIST_DEPTH];
	logic [OUT_COUNT_W-1:0] mirror_count [LIST_DEPTH];
	int                     mirror_fill;
	int                     mirror_cursor;

	// Results still owed by the block, oldest first.
	listing_t pending_listings[$];

	directed_row_t directed_rows [DIRECTED_ROWS];

	int  mismatches;
	int  compared;
	int  records_sent;
	int  nexts_sent;
	int  full_drops;
	int  empty_nexts;
	int  idle_cycles;
	bit  calm;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Applies one request to the shadow list and returns the result it must produce.
	// A hit bumps the count (holding at the top value) and bubbles the entry forward
	// while the entry ahead holds a strictly smaller count; equal counts keep their order.
	function automatic listing_t track_occurrence(input logic c, input logic [IN_KEY_W-1:0] k);
		listing_t               r;
		int                     pos;
		int                     i;
		logic [IN_KEY_W-1:0]    tk;
		logic [OUT_COUNT_W-1:0] tc;
		r = '0;
		if (c == CMD_NEXT) begin
			// An empty list answers with zeros and leaves the cursor where it is.
			if (mirror_fill == 0) begin
				r.status = STATUS_EMPTY;
				return r;
			end
			if (mirror_cursor >= mirror_fill)
				mirror_cursor = 0;
			r.key    = mirror_key[mirror_cursor];
			r.count  = mirror_count[mirror_cursor];
			r.rank   = mirror_cursor[RANK_W-1:0];
			r.status = STATUS_OK;
			mirror_cursor = mirror_cursor + 1;
			return r;
		end
		pos = -1;
		for (i = 0; i < mirror_fill; i++)
			if (pos < 0 && mirror_key[i] == k)
				pos = i;
		if (pos >= 0) begin
			if (mirror_count[pos] != '1)
				mirror_count[pos] = mirror_count[pos] + OUT_COUNT_W'(1);
			while (pos != 0 && mirror_count[pos] > mirror_count[pos-1]) begin
				tk = mirror_key[pos];
				tc = mirror_count[pos];
				mirror_key[pos]     = mirror_key[pos-1];
				mirror_count[pos]   = mirror_count[pos-1];
				mirror_key[pos-1]   = tk;
				mirror_count[pos-1] = tc;
				pos = pos - 1;
			end
			r.key    = mirror_key[pos];
			r.count  = mirror_count[pos];
			r.rank   = pos[RANK_W-1:0];
			r.status = STATUS_OK;
		end else if (mirror_fill >= LIST_DEPTH) begin
			// A miss on a full list drops the key and reports it back.
			r.key    = k;
			r.status = STATUS_FULL;
		end else begin
			mirror_key[mirror_fill]   = k;
			mirror_count[mirror_fill] = OUT_COUNT_W'(1);
			r.key    = k;
			r.count  = OUT_COUNT_W'(1);
			r.rank   = mirror_fill[RANK_W-1:0];
			r.status = STATUS_OK;
			mirror_fill = mirror_fill + 1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [IN_KEY_W-1:0] got,
		input logic [IN_KEY_W-1:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("ERROR @%0t: %s is %h, expected %h", $time, what, got, want);
	endtask

	// Presents one request and holds it until the block takes it. Outside calm
	// stretches the valid line may first drop. On acceptance the shadow list is
	// updated and the expected result queued: the hand-written one for typed
	// table rows, the shadow list's one otherwise.
	task automatic push_request(input logic c, input logic [IN_KEY_W-1:0] k,
		input logic typed, input listing_t want);
		listing_t got;
		if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		item_key <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = track_occurrence(c, k);
		pending_listings.insert(pending_listings.size(), typed ? want : got);
		if (c == CMD_NEXT)
			nexts_sent++;
		else
			records_sent++;
		if (got.status == STATUS_FULL)
			full_drops++;
		if (got.status == STATUS_EMPTY)
			empty_nexts++;
	endtask

	// The receiver stalls about a quarter of the time, except in calm stretches.
	always @(posedge clk) begin
		if (calm)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < IDLE_PERCENT);
	end

	// Every accepted result is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		listing_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_listings.size() == 0) begin
				report_mismatch("result with nothing pending, key", result_key, '0);
			end else begin
				want = pending_listings.pop_front();
				compared++;
				if (result_key !== want.key)
					report_mismatch("result_key", result_key, want.key);
				if (result_count !== want.count)
					report_mismatch("result_count", IN_KEY_W'(result_count),
						IN_KEY_W'(want.count));
				if (result_rank !== want.rank)
					report_mismatch("result_rank", IN_KEY_W'(result_rank),
						IN_KEY_W'(want.rank));
				if (status !== want.status)
					report_mismatch("status", IN_KEY_W'(status), IN_KEY_W'(want.status));
			end
		end
	end

	// The watchdog ends a run in which nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles, %0d results pending.",
				idle_cycles, pending_listings.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int n;
		int sel;

		arst_n        = 1'b0;
		in_valid      = 1'b0;
		cmd           = CMD_RECORD;
		item_key      = '0;
		out_stall     = 1'b0;
		calm          = 1'b0;
		mirror_fill   = 0;
		mirror_cursor = 0;
		mismatches    = 0;
		compared      = 0;
		records_sent  = 0;
		nexts_sent    = 0;
		full_drops    = 0;
		empty_nexts   = 0;
		idle_cycles   = 0;

		// Directed table. The first rows hit the empty list, the extreme keys and the
		// first appends; later rows cover a tie that must not reorder, a jump over two
		// entries at once and the cursor wrapping back to the front.
		directed_rows[0]  = {CMD_NEXT,   32'h0000_0000, 1'b1,
			{32'h0000_0000, 16'd0, 6'd0, STATUS_EMPTY}};
		directed_rows[1]  = {CMD_NEXT,   32'hFFFF_FFFF, 1'b1,
			{32'h0000_0000, 16'd0, 6'd0, STATUS_EMPTY}};
		directed_rows[2]  = {CMD_RECORD, 32'h0000_0000, 1'b1,
			{32'h0000_0000, 16'd1, 6'd0, STATUS_OK}};
		directed_rows[3]  = {CMD_RECORD, 32'hFFFF_FFFF, 1'b1,
			{32'hFFFF_FFFF, 16'd1, 6'd1, STATUS_OK}};
		directed_rows[4]  = {CMD_RECORD, 32'hFFFF_FFFF, 1'b0, NO_WANT};
		directed_rows[5]  = {CMD_RECORD, 32'h0000_0000, 1'b0, NO_WANT};
		directed_rows[6]  = {CMD_NEXT,   32'h1234_5678, 1'b0, NO_WANT};
		directed_rows[7]  = {CMD_NEXT,   32'h0000_0000, 1'b0, NO_WANT};
		directed_rows[8]  = {CMD_NEXT,   32'hFFFF_FFFF, 1'b0, NO_WANT};
		directed_rows[9]  = {CMD_RECORD, 32'h8000_0000, 1'b0, NO_WANT};
		directed_rows[10] = {CMD_RECORD, 32'h0000_0001, 1'b0, NO_WANT};
		directed_rows[11] = {CMD_RECORD, 32'h8000_0000, 1'b0, NO_WANT};
		directed_rows[12] = {CMD_RECORD, 32'h8000_0000, 1'b0, NO_WANT};
		directed_rows[13] = {CMD_RECORD, 32'h0000_0001, 1'b0, NO_WANT};
		directed_rows[14] = {CMD_NEXT,   32'h0000_0000, 1'b0, NO_WANT};
		directed_rows[15] = {CMD_NEXT,   32'h0000_0000, 1'b0, NO_WANT};
		directed_rows[16] = {CMD_NEXT,   32'h0000_0000, 1'b0, NO_WANT};
		directed_rows[17] = {CMD_NEXT,   32'h0000_0000, 1'b0, NO_WANT};
		directed_rows[18] = {CMD_NEXT,   32'h0000_0000, 1'b0, NO_WANT};
		directed_rows[19] = {CMD_RECORD, 32'h5A5A_5A5A, 1'b0, NO_WANT};
		directed_rows[20] = {CMD_RECORD, 32'hA5A5_A5A5, 1'b0, NO_WANT};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_ROWS; n++)
			push_request(directed_rows[n].cmd, directed_rows[n].key,
				directed_rows[n].typed, directed_rows[n].want);

		// Random traffic. Most records hit keys already in the list so counts climb and
		// entries reorder; the fresh keys fill the list to its depth, after which they
		// are dropped. A band in the middle runs with no idling on either side.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 300 && n < 400);
			sel  = $urandom_range(99);
			if (sel < 25)
				push_request(CMD_NEXT, $urandom, 1'b0, NO_WANT);
			else if (sel < 70 && mirror_fill > 0)
				push_request(CMD_RECORD, mirror_key[$urandom_range(mirror_fill - 1)],
					1'b0, NO_WANT);
			else if (sel < 78)
				push_request(CMD_RECORD, 32'($urandom_range(15)), 1'b0, NO_WANT);
			else
				push_request(CMD_RECORD, $urandom, 1'b0, NO_WANT);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// Drain: wait for every owed result, then give the pipeline time to show any
		// stray extra result. The watchdog bounds both waits.
		while (pending_listings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_listings.size() != 0)
			report_mismatch("results still pending", IN_KEY_W'(pending_listings.size()), '0);

		$display("Sent %0d records and %0d round-robin requests; compared %0d results.",
			records_sent, nexts_sent, compared);
		$display("Saw %0d full-list drops, %0d empty-list requests, a peak fill of %0d.",
			full_drops, empty_nexts, mirror_fill);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches.", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
